// ===== hw/rtl/mhes_pkg.sv =====
// ----------------------------------------------------------------------------
// mhes_pkg
// Shared types, command codes and helpers of the min-heap extract/sort block.
// ----------------------------------------------------------------------------
package mhes_pkg;

	localparam logic [2:0] CMD_CLEAR   = 3'd0;
	localparam logic [2:0] CMD_APPEND  = 3'd1;
	localparam logic [2:0] CMD_BUILD   = 3'd2;
	localparam logic [2:0] CMD_EXTRACT = 3'd3;
	localparam logic [2:0] CMD_DRAIN   = 3'd4;

	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [31:0] min_value;
		logic               was_empty;
		logic               last_of_run;
	} res_t;

	function automatic logic s_less(input logic signed [31:0] a, input logic signed [31:0] b);
		return a < b;
	endfunction

endpackage

// ===== hw/rtl/mhes_if.sv =====
// ----------------------------------------------------------------------------
// mhes_if
// Valid/ready channels: command items in, result items out.
// ----------------------------------------------------------------------------
interface mhes_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [31:0] value;

	modport source(output valid, output cmd, output value, input ready);
	modport sink(input valid, input cmd, input value, output ready);
endinterface

interface mhes_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] min_value;
	logic               was_empty;
	logic               last_of_run;

	modport source(output valid, output min_value, output was_empty, output last_of_run,
		input ready);
	modport sink(input valid, input min_value, input was_empty, input last_of_run,
		output ready);
endinterface

// ===== hw/rtl/mhes_store.sv =====
// ----------------------------------------------------------------------------
// mhes_store
// Element memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mhes_store #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
	output logic signed [31:0]            rd_data_a,
	output logic signed [31:0]            rd_data_b,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic signed [31:0]            wr_data
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== hw/rtl/mhes_out.sv =====
// ----------------------------------------------------------------------------
// mhes_out
// Result output register between the engine and the result channel.
// ----------------------------------------------------------------------------
module mhes_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mhes_pkg::res_t res,
	output logic          free,
	mhes_res_if.source    result
);

	logic           valid_q;
	mhes_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign free               = !valid_q || result.ready;
	assign result.valid       = valid_q;
	assign result.min_value   = res_q.min_value;
	assign result.was_empty   = res_q.was_empty;
	assign result.last_of_run = res_q.last_of_run;

endmodule

// ===== hw/rtl/mhes_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhes_ctrl
// Command sequencer: clear, append, build, extract and drain over the element
// memory, one sift-down level per cycle.
// ----------------------------------------------------------------------------
module mhes_ctrl #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mhes_cmd_if.sink                      request,
	output logic                          rd_en,
	output logic [$clog2(DEPTH)-1:0]      rd_addr_a,
	output logic [$clog2(DEPTH)-1:0]      rd_addr_b,
	input  logic signed [31:0]            rd_data_a,
	input  logic signed [31:0]            rd_data_b,
	output logic                          wr_en,
	output logic [$clog2(DEPTH)-1:0]      wr_addr,
	output logic signed [31:0]            wr_data,
	output logic                          push,
	output mhes_pkg::res_t                res,
	input  logic                          out_free
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = CW + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EMPTY  = 4'd1;
	localparam logic [3:0] S_EX_RD  = 4'd2;
	localparam logic [3:0] S_EX_LD  = 4'd3;
	localparam logic [3:0] S_BLD_RD = 4'd4;
	localparam logic [3:0] S_BLD_LD = 4'd5;
	localparam logic [3:0] S_SIFT   = 4'd6;
	localparam logic [3:0] S_CMP    = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	localparam logic [1:0] M_EXTRACT = 2'd0;
	localparam logic [1:0] M_DRAIN   = 2'd1;
	localparam logic [1:0] M_BUILD   = 2'd2;

	logic [3:0]         state_q;
	logic [1:0]         mode_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      node_q;
	logic [AW-1:0]      bidx_q;
	logic signed [31:0] cur_q;
	logic               right_ok_q;

	logic [LW-1:0]      count_l;
	logic [LW-1:0]      left_w;
	logic [LW-1:0]      right_w;
	logic               pick_left;
	logic               pick_right;
	logic               moved;
	logic signed [31:0] pick_val;
	logic signed [31:0] child_val;
	logic [LW-1:0]      child_idx;
	logic [LW-1:0]      nl_w;
	logic [LW-1:0]      nr_w;
	logic [CW-1:0]      count_m1;
	logic [CW-1:0]      last_parent;
	logic               can_append;

	assign count_l     = LW'(count_q);
	assign left_w      = (LW'(node_q) << 1) + LW'(1);
	assign right_w     = left_w + LW'(1);
	assign count_m1    = count_q - CW'(1);
	assign last_parent = (count_q - CW'(2)) >> 1;
	assign can_append  = count_q < CW'(DEPTH);

	// child choice: left wins ties
	assign pick_left  = mhes_pkg::s_less(rd_data_a, cur_q);
	assign pick_val   = pick_left ? rd_data_a : cur_q;
	assign pick_right = right_ok_q && mhes_pkg::s_less(rd_data_b, pick_val);
	assign moved      = pick_left || pick_right;
	assign child_val  = pick_right ? rd_data_b : rd_data_a;
	assign child_idx  = pick_right ? right_w : left_w;
	assign nl_w       = (child_idx << 1) + LW'(1);
	assign nr_w       = nl_w + LW'(1);

	assign request.ready = (state_q == S_IDLE);

	always_comb begin
		rd_en     = 1'b0;
		rd_addr_a = '0;
		rd_addr_b = '0;
		wr_en     = 1'b0;
		wr_addr   = node_q;
		wr_data   = cur_q;
		push      = 1'b0;
		res.min_value   = rd_data_a;
		res.was_empty   = 1'b0;
		res.last_of_run = (mode_q == M_EXTRACT) || (count_q == CW'(1));
		case (state_q)
			S_IDLE: begin
				if (request.valid && request.cmd == mhes_pkg::CMD_APPEND && can_append) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = request.value;
				end
			end
			S_EMPTY: begin
				push            = out_free;
				res.min_value   = mhes_pkg::INT_MAX;
				res.was_empty   = 1'b1;
				res.last_of_run = 1'b1;
			end
			S_EX_RD: begin
				rd_en     = 1'b1;
				rd_addr_a = '0;
				rd_addr_b = count_m1[AW-1:0];
			end
			S_EX_LD: begin
				push = out_free;
			end
			S_BLD_RD: begin
				rd_en     = 1'b1;
				rd_addr_a = bidx_q;
			end
			S_SIFT: begin
				if (left_w < count_l) begin
					rd_en     = 1'b1;
					rd_addr_a = left_w[AW-1:0];
					rd_addr_b = right_w[AW-1:0];
				end
			end
			S_CMP: begin
				if (moved) begin
					// child moves up; deeper reads never hit the written node
					wr_en   = 1'b1;
					wr_data = child_val;
					if (nl_w < count_l) begin
						rd_en     = 1'b1;
						rd_addr_a = nl_w[AW-1:0];
						rd_addr_b = nr_w[AW-1:0];
					end
				end
			end
			S_FIN: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= M_EXTRACT;
			count_q    <= '0;
			node_q     <= '0;
			bidx_q     <= '0;
			right_ok_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						case (request.cmd)
							mhes_pkg::CMD_CLEAR: begin
								count_q <= '0;
							end
							mhes_pkg::CMD_APPEND: begin
								if (can_append) begin
									count_q <= count_q + CW'(1);
								end
							end
							mhes_pkg::CMD_BUILD: begin
								if (count_q > CW'(1)) begin
									bidx_q  <= last_parent[AW-1:0];
									mode_q  <= M_BUILD;
									state_q <= S_BLD_RD;
								end
							end
							mhes_pkg::CMD_EXTRACT: begin
								mode_q  <= M_EXTRACT;
								state_q <= (count_q == '0) ? S_EMPTY : S_EX_RD;
							end
							mhes_pkg::CMD_DRAIN: begin
								if (count_q != '0) begin
									mode_q  <= M_DRAIN;
									state_q <= S_EX_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EX_RD: begin
					state_q <= S_EX_LD;
				end
				S_EX_LD: begin
					if (out_free) begin
						count_q <= count_m1;
						node_q  <= '0;
						state_q <= S_SIFT;
					end
				end
				S_BLD_RD: begin
					state_q <= S_BLD_LD;
				end
				S_BLD_LD: begin
					node_q  <= bidx_q;
					state_q <= S_SIFT;
				end
				S_SIFT: begin
					if (left_w < count_l) begin
						right_ok_q <= right_w < count_l;
						state_q    <= S_CMP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CMP: begin
					if (moved) begin
						node_q <= child_idx[AW-1:0];
						if (nl_w < count_l) begin
							right_ok_q <= nr_w < count_l;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					case (mode_q)
						M_DRAIN: begin
							state_q <= (count_q != '0) ? S_EX_RD : S_IDLE;
						end
						M_BUILD: begin
							if (bidx_q == '0) begin
								state_q <= S_IDLE;
							end else begin
								bidx_q  <= bidx_q - AW'(1);
								state_q <= S_BLD_RD;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the sifting value is loaded from the memory read data
	always_ff @(posedge clk) begin
		if (state_q == S_EX_LD) begin
			cur_q <= rd_data_b;
		end else if (state_q == S_BLD_LD) begin
			cur_q <= rd_data_a;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.was_empty) |-> (res.min_value == mhes_pkg::INT_MAX && res.last_of_run))
		else $error("empty result malformed");

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && mode_q == M_DRAIN && res.last_of_run) |=> (count_q == '0))
		else $error("drain flagged last with elements left");

endmodule

// ===== hw/rtl/min_heap_extract_sort_top.sv =====
// Sequence: clear and append are handled in S_IDLE; an extract result is read in S_EX_RD and
//   pushed from S_EX_LD into the result register, held back while that register is full.
// Drain extracts element by element until the heap is empty; build sifts each parent, last parent to root.
//   A sift-down is a chain of read-compare-write steps in S_CMP, one per heap level.
// Throughput: one command at a time; the result register lets the next command in early.
// Reset: arst_n clears the element count and handshake state; memory is left as is.
// ----------------------------------------------------------------------------
// min_heap_extract_sort_top
// Binary min-heap of signed 32-bit values with extract and sorted drain.
// ----------------------------------------------------------------------------
module min_heap_extract_sort_top #(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	mhes_cmd_if.sink   request,
	mhes_res_if.source result
);

	localparam int AW = $clog2(DEPTH);

	logic               rd_en;
	logic [AW-1:0]      rd_addr_a;
	logic [AW-1:0]      rd_addr_b;
	logic signed [31:0] rd_data_a;
	logic signed [31:0] rd_data_b;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               push;
	logic               out_free;
	mhes_pkg::res_t     res;

	mhes_store #(.DEPTH(DEPTH)) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	mhes_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.res       (res),
		.out_free  (out_free)
	);

	mhes_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

endmodule
